// File: sv/vram_block_dma_controller_macros.svh
// Assertion macros for the video-memory block DMA controller.
// Expects clk and rst_n in the scope of use.
`ifndef VRAM_BLOCK_DMA_CONTROLLER_MACROS_SVH
`define VRAM_BLOCK_DMA_CONTROLLER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define VBDMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define VBDMA_NEVER(label, cond, msg) \
    `VBDMA_ASSERT(label, !(cond), msg)

`endif

// File: sv/vbdma_pkg.sv
// Shared types and constants for the video-memory block DMA controller.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vbdma_pkg;

    localparam int ADDR_BYTES = 4;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_HBLANK = 2'd2
    } vbdma_cmd_e;

    localparam logic [2:0] REG_SRC_HI = 3'd0;
    localparam logic [2:0] REG_SRC_LO = 3'd1;
    localparam logic [2:0] REG_DST_HI = 3'd2;
    localparam logic [2:0] REG_DST_LO = 3'd3;
    localparam logic [2:0] REG_LENGTH = 3'd4;

    localparam logic [7:0] READ_IDLE   = 8'hFF;
    localparam logic [7:0] HBLANK_STEP = 8'h10;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] reg_sel;
        logic [7:0] write_data;
        logic       cur_bank;
    } vbdma_req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        copy_valid;
        logic [15:0] copy_source;
        logic [12:0] copy_dest_offset;
        logic [11:0] copy_length;
        logic        copy_bank;
        logic [12:0] stall_added;
    } vbdma_rsp_t;

endpackage

`default_nettype wire

// File: sv/vram_block_dma_controller.sv
// Video-memory block DMA controller: request register, decode core, result register.
// Depends on vbdma_pkg, vbdma_core and vram_block_dma_controller_macros.svh.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries register writes,
//   register reads and horizontal-blank events. Every request yields exactly
//   one result on the rsp channel (rsp_valid / rsp_stall / rsp), in order.
//   A result with copy_valid set describes one block copy into video memory.
//   Path: an accepted request is held in the request register, then decoded into
//   the result register when that register can take it, and taken from there.
//   Throughput: one request per cycle while req_stall is low; decode is a
//   single pass between the request register and the result register.
//   Stall: while the result register holds an untaken result and rsp_stall
//   is high, a registered request waits and req_stall rises once the request
//   register is also full; nothing is dropped or repeated.
//   Reset: rst_n clears the address bytes, the hblank transfer state and both
//   pipeline valids; requests can be taken as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "vram_block_dma_controller_macros.svh"

module vram_block_dma_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    input  wire vbdma_pkg::vbdma_req_t req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    output vbdma_pkg::vbdma_rsp_t      rsp
);

    logic                  req_valid_reg;
    logic                  req_valid_next;
    vbdma_pkg::vbdma_req_t req_reg;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    vbdma_pkg::vbdma_rsp_t rsp_reg;
    vbdma_pkg::vbdma_rsp_t rsp_next;
    logic                  take;
    logic                  adv;

    assign adv       = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && rsp_valid_reg && rsp_stall;
    assign take      = req_valid && !req_stall;

    assign req_valid_next = take || (req_valid_reg && !adv);
    assign rsp_valid_next = adv || (rsp_valid_reg && rsp_stall);

    vbdma_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .req   (req_reg),
        .rsp   (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            req_reg <= req;
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `VBDMA_NEVER(a_no_overwrite, adv && rsp_valid_reg && rsp_stall, "result overwritten")
    `VBDMA_ASSERT(a_stall_full, req_stall |-> (req_valid_reg && rsp_valid_reg), "spurious stall")
    `VBDMA_ASSERT(a_empty_desc, (rsp_valid && !rsp.copy_valid) |-> (rsp.copy_source == 16'd0 && rsp.copy_length == 12'd0 && rsp.stall_added == 13'd0), "fields set without copy")
    `VBDMA_ASSERT(a_hblank_len, (rsp_valid && rsp.copy_valid && rsp.stall_added == 13'd0) |-> (rsp.copy_length == 12'd16), "bad hblank length")

endmodule

`default_nettype wire

// File: sv/vbdma_core.sv
// DMA register state and per-request decode for the block DMA controller.
// Depends on vbdma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbdma_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire vbdma_pkg::vbdma_req_t req,
    output vbdma_pkg::vbdma_rsp_t  rsp
);

    logic [7:0]  addr_byte_reg [vbdma_pkg::ADDR_BYTES];
    logic        active_reg;
    logic        active_next;
    logic [15:0] src_reg;
    logic [15:0] src_next;
    logic [12:0] dst_reg;
    logic [12:0] dst_next;
    logic [7:0]  blocks_reg;
    logic [7:0]  blocks_next;
    logic        bank_reg;
    logic        bank_next;
    logic        byte_we;

    logic [15:0] form_src;
    logic [12:0] form_dst;
    logic [7:0]  blocks;
    logic [7:0]  blocks_m1;

    assign form_src  = {addr_byte_reg[0], addr_byte_reg[1][7:4], 4'b0000};
    assign form_dst  = {addr_byte_reg[2][4:0], addr_byte_reg[3][7:4], 4'b0000};
    assign blocks    = {1'b0, req.write_data[6:0]} + 8'd1;
    assign blocks_m1 = blocks_reg - 8'd1;

    always_comb
    begin
        rsp         = '0;
        active_next = active_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        blocks_next = blocks_reg;
        bank_next   = bank_reg;
        byte_we     = 1'b0;
        unique case (req.command)
            vbdma_pkg::CMD_WRITE:
            begin
                if (req.reg_sel[2] == 1'b0)
                begin
                    byte_we = 1'b1;
                end
                else if (req.reg_sel == vbdma_pkg::REG_LENGTH)
                begin
                    if (req.write_data[7])
                    begin
                        active_next = 1'b1;
                        src_next    = form_src;
                        dst_next    = form_dst;
                        blocks_next = blocks;
                        bank_next   = req.cur_bank;
                    end
                    else if (active_reg)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        rsp.copy_valid       = 1'b1;
                        rsp.copy_source      = form_src;
                        rsp.copy_dest_offset = form_dst;
                        rsp.copy_length      = {blocks, 4'b0000};
                        rsp.copy_bank        = req.cur_bank;
                        rsp.stall_added      = {blocks, 5'b00000};
                    end
                end
            end
            vbdma_pkg::CMD_READ:
            begin
                if (req.reg_sel[2] == 1'b0)
                    rsp.read_data = addr_byte_reg[req.reg_sel[1:0]];
                else if (req.reg_sel == vbdma_pkg::REG_LENGTH && active_reg)
                    rsp.read_data = {1'b0, blocks_m1[6:0]};
                else
                    rsp.read_data = vbdma_pkg::READ_IDLE;
            end
            vbdma_pkg::CMD_HBLANK:
            begin
                if (active_reg)
                begin
                    rsp.copy_valid       = 1'b1;
                    rsp.copy_source      = src_reg;
                    rsp.copy_dest_offset = dst_reg;
                    rsp.copy_length      = {4'b0000, vbdma_pkg::HBLANK_STEP};
                    rsp.copy_bank        = bank_reg;
                    src_next    = src_reg + {8'd0, vbdma_pkg::HBLANK_STEP};
                    dst_next    = dst_reg + {5'd0, vbdma_pkg::HBLANK_STEP};
                    blocks_next = blocks_m1;
                    active_next = (blocks_m1 != 8'd0);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vbdma_pkg::ADDR_BYTES; i++)
                addr_byte_reg[i] <= 8'd0;
            active_reg <= 1'b0;
            src_reg    <= 16'd0;
            dst_reg    <= 13'd0;
            blocks_reg <= 8'd0;
            bank_reg   <= 1'b0;
        end
        else if (en)
        begin
            if (byte_we)
                addr_byte_reg[req.reg_sel[1:0]] <= req.write_data;
            active_reg <= active_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            blocks_reg <= blocks_next;
            bank_reg   <= bank_next;
        end
    end

endmodule

`default_nettype wire
